// ===== design/button_event_qualifier_unit_assert.svh =====
// Assertion macros used by the checker of the button event qualifier.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef BUTTON_EVENT_QUALIFIER_UNIT_ASSERT_SVH
`define BUTTON_EVENT_QUALIFIER_UNIT_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define BEQ_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define BEQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/beq_pkg.sv =====
// Types, constants and detector functions for the button event qualifier.
// Depends on nothing; used by button_event_qualifier_unit.
`default_nettype none

package beq_pkg;

	localparam int unsigned TIME_W  = 32;
	localparam int unsigned COUNT_W = 16;
	localparam int unsigned CFG_IDX_W = 2;

	localparam logic [TIME_W-1:0] DEBOUNCE_RESET = 32'd50;
	localparam logic [TIME_W-1:0] SPACING_RESET  = 32'd500000;
	localparam logic [COUNT_W-1:0] COUNT_MAX     = 16'hFFFF;

	localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SPACING  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MODE     = 2'd2;

	localparam logic MODE_HOLD  = 1'b0;
	localparam logic MODE_CLICK = 1'b1;

	typedef struct packed {
		logic              fire;
		logic              armed;
		logic [TIME_W-1:0] stamp;
	} det_t;

	// A high sample restamps and arms; a debounced low fires once.
	function automatic det_t press_det(
		input logic              high,
		input logic [TIME_W-1:0] now,
		input logic [TIME_W-1:0] stamp,
		input logic              armed,
		input logic [TIME_W-1:0] debounce
	);
		det_t r;
		logic [TIME_W-1:0] diff;
		diff = now - stamp;
		r.fire = 1'b0;
		r.armed = armed;
		r.stamp = stamp;
		if (high) begin
			r.stamp = now;
			r.armed = 1'b1;
		end else if ((diff > debounce) && armed) begin
			r.armed = 1'b0;
			r.fire = 1'b1;
		end
		return r;
	endfunction

	// A debounced low arms; the next high restamps and fires once if armed.
	function automatic det_t release_det(
		input logic              high,
		input logic [TIME_W-1:0] now,
		input logic [TIME_W-1:0] stamp,
		input logic              armed,
		input logic [TIME_W-1:0] debounce
	);
		det_t r;
		logic [TIME_W-1:0] diff;
		diff = now - stamp;
		r.fire = 1'b0;
		r.armed = armed;
		r.stamp = stamp;
		if (high) begin
			r.stamp = now;
			r.fire = armed;
			r.armed = 1'b0;
		end else if (diff > debounce) begin
			r.armed = 1'b1;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== design/button_event_qualifier_unit.sv =====
// Button event qualifier: debounced press and release events and a shared
// hold-repeat or multi-click count. Uses beq_pkg.
//
// The block takes one pin sample per clock while in_stall is low and gives one
// result word per sample: the sample passes through the input register and then
// the result register. All detector state is updated from the input register
// as the result register is loaded, so a new sample can follow in every cycle
// in which no finished word waits on a stalled output. While such a word waits,
// the input register still takes one more sample. Register writes are always
// taken and should be made while no sample is in flight.
`default_nettype none

module button_event_qualifier_unit import beq_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output      logic                 in_stall,
	input  wire logic                 pin_level,
	input  wire logic [TIME_W-1:0]    now_us,
	output      logic                 out_valid,
	input  wire logic                 out_stall,
	output      logic                 release_event,
	output      logic                 press_event,
	output      logic [COUNT_W-1:0]   event_count,
	input  wire logic                 cfg_valid,
	output      logic                 cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [TIME_W-1:0]    cfg_data
);

	logic [TIME_W-1:0] debounce_q;
	logic [TIME_W-1:0] spacing_q;
	logic              mode_q;

	logic              valid_s1;
	logic              pin_s1;
	logic [TIME_W-1:0] now_s1;

	logic              out_valid_q;
	logic              release_q;
	logic              press_q;
	logic [COUNT_W-1:0] count_out_q;

	det_t rel_q, prs_q, hb_q, he_q, cb_q;
	logic [COUNT_W-1:0] count_q;
	logic [TIME_W-1:0]  istart_q;

	det_t rel_d, prs_d, hb_d, he_d, cb_d;
	det_t hb_n, he_n, cb_n;
	logic [COUNT_W-1:0] count_d;
	logic [TIME_W-1:0]  istart_d;
	logic [TIME_W-1:0]  ielapsed;
	logic               advance;
	logic               take_in;

	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !advance;
	assign take_in   = in_valid && !in_stall;

	assign out_valid     = out_valid_q;
	assign release_event = release_q;
	assign press_event   = press_q;
	assign event_count   = count_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= DEBOUNCE_RESET;
			spacing_q  <= SPACING_RESET;
			mode_q     <= MODE_HOLD;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_DEBOUNCE: debounce_q <= cfg_data;
				CFG_SPACING:  spacing_q  <= cfg_data;
				CFG_MODE:     mode_q     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_in) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			pin_s1 <= pin_level;
			now_s1 <= now_us;
		end
	end

	always_comb begin
		rel_d = release_det(pin_s1, now_s1, rel_q.stamp, rel_q.armed, debounce_q);
		prs_d = press_det(pin_s1, now_s1, prs_q.stamp, prs_q.armed, debounce_q);
		hb_n  = press_det(pin_s1, now_s1, hb_q.stamp, hb_q.armed, debounce_q);
		he_n  = release_det(pin_s1, now_s1, he_q.stamp, he_q.armed, debounce_q);
		cb_n  = press_det(pin_s1, now_s1, cb_q.stamp, cb_q.armed, debounce_q);
		ielapsed = now_s1 - istart_q;
		hb_d = hb_q;
		he_d = he_q;
		cb_d = cb_q;
		count_d = count_q;
		istart_d = istart_q;
		if (mode_q == MODE_HOLD) begin
			hb_d = hb_n;
			he_d = he_n;
			if (hb_n.fire) begin
				count_d = COUNT_W'(1);
				istart_d = now_s1;
			end else if ((count_q != '0) && (ielapsed > spacing_q)) begin
				if (count_q != COUNT_MAX) begin
					count_d = count_q + COUNT_W'(1);
				end
				istart_d = now_s1;
			end
			if (he_n.fire) begin
				count_d = '0;
			end
		end else begin
			if (count_q == '0) begin
				cb_d = cb_n;
				if (cb_n.fire) begin
					count_d = COUNT_W'(1);
					istart_d = now_s1;
				end
			end else if (ielapsed < spacing_q) begin
				cb_d = cb_n;
				if (cb_n.fire) begin
					if (count_q != COUNT_MAX) begin
						count_d = count_q + COUNT_W'(1);
					end
					istart_d = now_s1;
				end
			end else begin
				count_d = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rel_q    <= '0;
			prs_q    <= '0;
			hb_q     <= '0;
			he_q     <= '0;
			cb_q     <= '0;
			count_q  <= '0;
			istart_q <= '0;
		end else if (advance) begin
			rel_q    <= rel_d;
			prs_q    <= prs_d;
			hb_q     <= hb_d;
			he_q     <= he_d;
			cb_q     <= cb_d;
			count_q  <= count_d;
			istart_q <= istart_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			release_q   <= rel_d.fire;
			press_q     <= prs_d.fire;
			count_out_q <= count_d;
		end
	end

endmodule

`default_nettype wire

// ===== design/beq_checker.sv =====
// Port-level checker for the button event qualifier, bound to its top level.
// Depends on beq_pkg and button_event_qualifier_unit_assert.svh.
`default_nettype none

`include "button_event_qualifier_unit_assert.svh"

module beq_checker import beq_pkg::*; (
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 in_valid,
	input wire logic                 in_stall,
	input wire logic                 out_valid,
	input wire logic                 out_stall,
	input wire logic                 release_event,
	input wire logic                 press_event,
	input wire logic [COUNT_W-1:0]   event_count
);

	`BEQ_ASSERT_NEXT(a_out_valid_holds, out_valid && out_stall, out_valid, "output word dropped while stalled")
	`BEQ_ASSERT_NEXT(a_out_word_holds, out_valid && out_stall, ($stable({release_event, press_event, event_count})), "stalled output word changed")
	`BEQ_ASSERT_SAME(a_no_press_and_release, out_valid, !(press_event && release_event), "press and release reported on one sample")
	`BEQ_ASSERT_SAME(a_word_follows_sample, in_valid && !in_stall, ##2 out_valid, "accepted sample produced no output word")

endmodule

bind button_event_qualifier_unit beq_checker u_beq_checker (.*);

`default_nettype wire
